[src/utf8_dfa_decoder_unit_defines.svh]
// Assertion macros for the UTF-8 decoder unit
`ifndef UTF8_DFA_DECODER_UNIT_DEFINES_SVH
`define UTF8_DFA_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define UDD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define UDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/udd_pkg.sv]
`default_nettype none

package udd_pkg;

	typedef logic [3:0] udd_state_t;
	typedef logic [3:0] udd_class_t;

	localparam udd_state_t ST_ACCEPT = 4'd0;
	localparam udd_state_t ST_REJECT = 4'd1;
	localparam udd_state_t ST_LAST   = 4'd8;

	localparam int CP_W = 21;

	// Byte classes
	localparam udd_class_t CL_ASCII   = 4'h0;
	localparam udd_class_t CL_CONT_8X = 4'h1;
	localparam udd_class_t CL_LEAD2   = 4'h2;
	localparam udd_class_t CL_LEAD3   = 4'h3;
	localparam udd_class_t CL_ED      = 4'h4;
	localparam udd_class_t CL_F4      = 4'h5;
	localparam udd_class_t CL_LEAD4   = 4'h6;
	localparam udd_class_t CL_CONT_AB = 4'h7;
	localparam udd_class_t CL_INVALID = 4'h8;
	localparam udd_class_t CL_CONT_9X = 4'h9;
	localparam udd_class_t CL_E0      = 4'hA;
	localparam udd_class_t CL_F0      = 4'hB;

	// Transition table, indexed [state][class]
	localparam udd_state_t NEXT_STATE [9][16] = '{
		'{4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6,4'd1,4'd1,4'd1,4'd1},
		'{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
		'{4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
		'{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
		'{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
		'{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
		'{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
		'{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
		'{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1}
	};

	// Map a raw byte to its class
	function automatic udd_class_t byte_class(input logic [7:0] b);
		udd_class_t c;
		if (b <= 8'h7F)       c = CL_ASCII;
		else if (b <= 8'h8F)  c = CL_CONT_8X;
		else if (b <= 8'h9F)  c = CL_CONT_9X;
		else if (b <= 8'hBF)  c = CL_CONT_AB;
		else if (b <= 8'hC1)  c = CL_INVALID;
		else if (b <= 8'hDF)  c = CL_LEAD2;
		else if (b == 8'hE0)  c = CL_E0;
		else if (b == 8'hED)  c = CL_ED;
		else if (b <= 8'hEF)  c = CL_LEAD3;
		else if (b == 8'hF0)  c = CL_F0;
		else if (b <= 8'hF3)  c = CL_LEAD4;
		else if (b == 8'hF4)  c = CL_F4;
		else                  c = CL_INVALID;
		return c;
	endfunction

endpackage

`default_nettype wire

[src/utf8_dfa_decoder_unit.sv]
// A byte accepted on the input is held in the input register; its result (if any) then goes to the result register.
// One byte per cycle while the output is not stalled, set by the update of the DFA state register.
// Reset (arst_n low, asynchronous): both stages empty, DFA in accept, partial code zero.
`default_nettype none
`include "utf8_dfa_decoder_unit_defines.svh"

module utf8_dfa_decoder_unit
	import udd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
	input  wire logic        s_tlast,   // end_of_text
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [20:0] code_point, [23:21] zero
	output logic             m_tuser    // is_error
);

	// Input stage
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	// Decoder state
	udd_state_t       state_q;
	logic [CP_W-1:0]  partial_q;

	// Result register
	logic             out_valid_q;
	logic [CP_W-1:0]  out_code_q;
	logic             out_err_q;

	logic             out_free;
	logic             advance;
	udd_class_t       cls;
	udd_state_t       ns;
	logic [CP_W-1:0]  pc_next;
	logic             emit_ok;
	logic             emit_err;

	// Flow control
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || advance;

	// One DFA step
	always_comb begin
		cls = byte_class(byte_s1);
		if (state_q > ST_LAST) begin
			ns      = ST_REJECT;
			pc_next = partial_q;
		end else begin
			ns = NEXT_STATE[state_q][cls];
			if (state_q == ST_ACCEPT) begin
				pc_next = {{(CP_W-8){1'b0}}, byte_s1 & (8'hFF >> cls)};
			end else begin
				pc_next = {partial_q[CP_W-7:0], byte_s1[5:0]};
			end
		end
		emit_ok  = (ns == ST_ACCEPT);
		emit_err = !emit_ok && ((ns == ST_REJECT) || last_s1);
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// DFA state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_ACCEPT;
			partial_q <= '0;
		end else if (advance) begin
			if (emit_ok || emit_err) begin
				state_q   <= ST_ACCEPT;
				partial_q <= '0;
			end else begin
				state_q   <= ns;
				partial_q <= pc_next;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && (emit_ok || emit_err);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_code_q <= emit_ok ? pc_next : '0;
			out_err_q  <= !emit_ok;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_code_q};
	assign m_tuser  = out_err_q;

	// Checks
	`UDD_ASSERT_NOW(a_err_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata[20:0] == 21'd0, "error result carries nonzero code point")
	`UDD_ASSERT_NOW(a_state_range, clk, arst_n, 1'b1, state_q <= ST_LAST && state_q != ST_REJECT, "DFA holds an illegal state")
	`UDD_ASSERT_NOW(a_accept_clear, clk, arst_n, state_q == ST_ACCEPT, partial_q == '0, "partial code not cleared in accept")
	`UDD_ASSERT_NOW(a_scalar, clk, arst_n, m_tvalid && !m_tuser, (m_tdata[20:0] <= 21'h10FFFF) && !((m_tdata[20:0] >= 21'h00D800) && (m_tdata[20:0] <= 21'h00DFFF)), "emitted value is not a scalar value")
	`UDD_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !out_free, valid_s1 && $stable(byte_s1) && $stable(last_s1), "stalled request lost in input stage")

endmodule

`default_nettype wire
